// File: src/lwa_pkg.sv
// shared types and constants for the lax-wendroff advection step
`default_nettype none

package lwa_pkg;

	localparam int DEF_MAX_POINTS   = 65536;
	localparam int DEF_SAMPLE_WIDTH = 32;
	localparam int INDEX_WIDTH      = 16;
	localparam int COUNT_WIDTH      = 17;
	localparam int COEF_WIDTH       = 32;
	localparam int COEF_FRAC        = 30;
	localparam int INDEX_LIMIT      = 65536;
	localparam int MIN_POINTS       = 3;

	typedef enum logic [1:0] {
		MODE_FIXED    = 2'd0,
		MODE_PERIODIC = 2'd1,
		MODE_FREE     = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_POINT_COUNT   = 2'd0,
		REG_BOUNDARY_MODE = 2'd1,
		REG_HALF_COURANT  = 2'd2,
		REG_HALF_COURANT2 = 2'd3
	} reg_idx_t;

	// control that travels with each stencil job down the pipeline
	typedef struct packed {
		logic [INDEX_WIDTH-1:0] index;
		logic                   copy;
		logic                   last;
		logic                   done;
	} job_ctl_t;

endpackage

`default_nettype wire

// File: src/lwa_stencil.sv
// three-stage stencil pipeline: operand register, products, rounded and saturated result
`default_nettype none

module lwa_stencil #(
	parameter int SAMPLE_WIDTH = lwa_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    job_valid,
	output logic                                         job_ready,
	input  wire lwa_pkg::job_ctl_t                       job_ctl,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          job_l,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          job_c,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          job_r,
	input  wire logic signed [lwa_pkg::COEF_WIDTH-1:0]   half_courant,
	input  wire logic signed [lwa_pkg::COEF_WIDTH-1:0]   half_courant_squared,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output lwa_pkg::job_ctl_t                            out_ctl,
	output logic signed [SAMPLE_WIDTH-1:0]               out_value
);

	localparam int W   = SAMPLE_WIDTH;
	localparam int CW  = lwa_pkg::COEF_WIDTH;
	localparam int FR  = lwa_pkg::COEF_FRAC;
	localparam int D1W = W + 1;
	localparam int D2W = W + 2;
	localparam int P1W = D1W + CW;
	localparam int P2W = D2W + CW;
	localparam int AW  = W + CW + 4;
	localparam int QW  = AW - FR;

	localparam logic signed [AW-1:0] ROUND = {{(AW-FR){1'b0}}, 1'b1, {(FR-1){1'b0}}};
	localparam logic signed [W-1:0]  VMAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  VMIN  = {1'b1, {(W-1){1'b0}}};

	logic                   valid_s1, valid_s2, valid_s3;
	logic                   adv1, adv2, adv3;
	lwa_pkg::job_ctl_t      ctl_s1, ctl_s2, ctl_s3;
	logic signed [W-1:0]    l_s1, c_s1, r_s1, c_s2, value_s3;
	logic signed [D1W-1:0]  d1;
	logic signed [D2W-1:0]  d2;
	logic signed [P1W-1:0]  p1, p1_s2;
	logic signed [P2W-1:0]  p2, p2_s2;
	logic signed [AW-1:0]   acc;
	logic signed [QW-1:0]   q;
	logic signed [W-1:0]    sat;

	assign adv3      = !valid_s3 || out_ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign job_ready = adv1;

	// c - hc*(r - l) + hcs*(r + l - 2c), with c carried at 2^30 scale
	assign d1 = {l_s1[W-1], l_s1} - {r_s1[W-1], r_s1};
	assign d2 = {{2{r_s1[W-1]}}, r_s1} + {{2{l_s1[W-1]}}, l_s1} - {c_s1[W-1], c_s1, 1'b0};
	assign p1 = P1W'(half_courant) * P1W'(d1);
	assign p2 = P2W'(half_courant_squared) * P2W'(d2);

	assign acc = AW'($signed({c_s2, {FR{1'b0}}})) + AW'(p1_s2) + AW'(p2_s2) + ROUND;
	assign q   = acc[AW-1:FR];

	always_comb begin
		if (q[QW-1:W-1] != {(QW-W+1){1'b0}} && q[QW-1:W-1] != {(QW-W+1){1'b1}}) begin
			sat = q[QW-1] ? VMIN : VMAX;
		end else begin
			sat = q[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= job_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && job_valid) begin
			ctl_s1 <= job_ctl;
			l_s1   <= job_l;
			c_s1   <= job_c;
			r_s1   <= job_r;
		end
		if (adv2 && valid_s1) begin
			ctl_s2 <= ctl_s1;
			c_s2   <= c_s1;
			p1_s2  <= p1;
			p2_s2  <= p2;
		end
		if (adv3 && valid_s2) begin
			ctl_s3   <= ctl_s2;
			value_s3 <= ctl_s2.copy ? c_s2 : sat;
		end
	end

	assign out_valid = valid_s3;
	assign out_ctl   = ctl_s3;
	assign out_value = value_s3;

endmodule

`default_nettype wire

// File: src/lax_wendroff_advection_step.sv
// top level: row sequencer, boundary handling, configuration registers
// One Lax-Wendroff advection step over a row of Q16.16 grid samples streamed in index order.
// Each sample is accepted and turned into at most three stencil jobs; the single
// stencil pipeline takes one job per cycle while the output does not stall it, so a
// sample that yields two or three results (the row end, and the third sample of a row in
// free-ends mode) holds the input until its waiting jobs have entered the pipeline.
// The output register holds one result and the pipeline keeps taking samples while it waits,
// as long as a stage is free.
// Configuration writes are taken in any cycle but must only be made while the block is idle.
`default_nettype none

module lax_wendroff_advection_step #(
	parameter int MAX_POINTS   = lwa_pkg::DEF_MAX_POINTS,
	parameter int SAMPLE_WIDTH = lwa_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [1:0]                             cfg_index,
	input  wire logic [lwa_pkg::COEF_WIDTH-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]         prev_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [lwa_pkg::INDEX_WIDTH-1:0]             point_index,
	output logic signed [SAMPLE_WIDTH-1:0]              next_sample,
	output logic                                        last_of_run,
	output logic                                        row_done
);

	localparam int W     = SAMPLE_WIDTH;
	localparam int IW    = lwa_pkg::INDEX_WIDTH;
	localparam int NW    = lwa_pkg::COUNT_WIDTH;
	localparam int CW    = lwa_pkg::COEF_WIDTH;
	localparam int LIMIT = (MAX_POINTS < lwa_pkg::INDEX_LIMIT) ? MAX_POINTS
	                                                           : lwa_pkg::INDEX_LIMIT;

	logic [NW-1:0]          point_count_q;
	logic [1:0]             mode_q;
	logic signed [CW-1:0]   hc_q, hcs_q;

	logic [IW-1:0]          sample_count_q;
	logic signed [W-1:0]    left_q, center_q, first_q, second_q;

	lwa_pkg::mode_t         mode;
	logic [NW-1:0]          n_eff, last_idx;
	logic                   last_hit, row_last, accept;

	logic signed [W-1:0]    slot_l [3];
	logic signed [W-1:0]    slot_c [3];
	logic signed [W-1:0]    slot_r [3];
	lwa_pkg::job_ctl_t      slot_ctl [3];
	logic [1:0]             job_n;

	logic [1:0]             pend_cnt_q;
	logic signed [W-1:0]    pend_l_q [2];
	logic signed [W-1:0]    pend_c_q [2];
	logic signed [W-1:0]    pend_r_q [2];
	lwa_pkg::job_ctl_t      pend_ctl_q [2];

	logic                   job_valid, job_ready, issue_pend;
	lwa_pkg::job_ctl_t      job_ctl, out_ctl;
	logic signed [W-1:0]    job_l, job_c, job_r;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= NW'(lwa_pkg::MIN_POINTS);
			mode_q        <= lwa_pkg::MODE_FIXED;
			hc_q          <= '0;
			hcs_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (lwa_pkg::reg_idx_t'(cfg_index))
				lwa_pkg::REG_POINT_COUNT:   point_count_q <= cfg_data[NW-1:0];
				lwa_pkg::REG_BOUNDARY_MODE: mode_q        <= cfg_data[1:0];
				lwa_pkg::REG_HALF_COURANT:  hc_q          <= cfg_data;
				lwa_pkg::REG_HALF_COURANT2: hcs_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// unused mode code behaves as fixed ends
	always_comb begin
		case (mode_q)
			lwa_pkg::MODE_PERIODIC: mode = lwa_pkg::MODE_PERIODIC;
			lwa_pkg::MODE_FREE:     mode = lwa_pkg::MODE_FREE;
			default:                mode = lwa_pkg::MODE_FIXED;
		endcase
	end

	always_comb begin
		if (point_count_q < NW'(lwa_pkg::MIN_POINTS)) begin
			n_eff = NW'(lwa_pkg::MIN_POINTS);
		end else if (point_count_q > NW'(LIMIT)) begin
			n_eff = NW'(LIMIT);
		end else begin
			n_eff = point_count_q;
		end
	end

	assign last_idx = n_eff - NW'(1);
	assign last_hit = {1'b0, sample_count_q} >= last_idx;

	// jobs caused by the incoming sample, in emission order
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			slot_l[i]   = '0;
			slot_c[i]   = '0;
			slot_r[i]   = '0;
			slot_ctl[i] = '0;
		end
		job_n    = '0;
		row_last = 1'b0;
		if (sample_count_q == '0) begin
			if (mode == lwa_pkg::MODE_FIXED) begin
				slot_c[0]        = prev_sample;
				slot_ctl[0].copy = 1'b1;
				job_n            = 2'd1;
			end
		end else if (sample_count_q != IW'(1)) begin
			row_last = last_hit;
			if (mode == lwa_pkg::MODE_FREE && sample_count_q == IW'(2)) begin
				slot_l[0] = left_q;
				slot_c[0] = center_q;
				slot_r[0] = prev_sample;
				job_n     = 2'd1;
			end
			slot_l[job_n]         = left_q;
			slot_c[job_n]         = center_q;
			slot_r[job_n]         = prev_sample;
			slot_ctl[job_n].index = sample_count_q - IW'(1);
			job_n                 = job_n + 2'd1;
			if (row_last) begin
				case (mode)
					lwa_pkg::MODE_PERIODIC: begin
						slot_l[job_n]         = center_q;
						slot_c[job_n]         = prev_sample;
						slot_r[job_n]         = first_q;
						slot_ctl[job_n].index = sample_count_q;
						job_n                 = job_n + 2'd1;
						// point 0 wraps: left neighbour is the last sample
						slot_l[job_n]         = prev_sample;
						slot_c[job_n]         = first_q;
						slot_r[job_n]         = second_q;
						job_n                 = job_n + 2'd1;
					end
					lwa_pkg::MODE_FREE: begin
						slot_l[job_n]         = left_q;
						slot_c[job_n]         = center_q;
						slot_r[job_n]         = prev_sample;
						slot_ctl[job_n].index = sample_count_q;
						job_n                 = job_n + 2'd1;
					end
					default: begin
						slot_c[job_n]         = prev_sample;
						slot_ctl[job_n].copy  = 1'b1;
						slot_ctl[job_n].index = sample_count_q;
						job_n                 = job_n + 2'd1;
					end
				endcase
			end
		end
		if (job_n != '0) begin
			slot_ctl[job_n - 2'd1].last = 1'b1;
			slot_ctl[job_n - 2'd1].done = row_last;
		end
	end

	assign issue_pend = (pend_cnt_q != '0) && job_ready;
	assign in_ready   = job_ready && (pend_cnt_q == '0);
	assign accept     = in_valid && in_ready;
	assign job_valid  = (pend_cnt_q != '0) || (in_valid && job_n != '0);
	assign job_ctl    = (pend_cnt_q != '0) ? pend_ctl_q[0] : slot_ctl[0];
	assign job_l      = (pend_cnt_q != '0) ? pend_l_q[0]   : slot_l[0];
	assign job_c      = (pend_cnt_q != '0) ? pend_c_q[0]   : slot_c[0];
	assign job_r      = (pend_cnt_q != '0) ? pend_r_q[0]   : slot_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q     <= '0;
			sample_count_q <= '0;
		end else if (accept) begin
			pend_cnt_q <= (job_n == '0) ? 2'd0 : job_n - 2'd1;
			if (sample_count_q == '0) begin
				sample_count_q <= IW'(1);
			end else if (sample_count_q == IW'(1)) begin
				sample_count_q <= IW'(2);
			end else if (last_hit) begin
				sample_count_q <= '0;
			end else begin
				sample_count_q <= sample_count_q + IW'(1);
			end
		end else if (issue_pend) begin
			pend_cnt_q <= pend_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_l_q[0]   <= slot_l[1];
			pend_c_q[0]   <= slot_c[1];
			pend_r_q[0]   <= slot_r[1];
			pend_ctl_q[0] <= slot_ctl[1];
			pend_l_q[1]   <= slot_l[2];
			pend_c_q[1]   <= slot_c[2];
			pend_r_q[1]   <= slot_r[2];
			pend_ctl_q[1] <= slot_ctl[2];
			if (sample_count_q == '0) begin
				first_q  <= prev_sample;
				center_q <= prev_sample;
			end else begin
				if (sample_count_q == IW'(1)) begin
					second_q <= prev_sample;
				end
				left_q   <= center_q;
				center_q <= prev_sample;
			end
		end else if (issue_pend) begin
			pend_l_q[0]   <= pend_l_q[1];
			pend_c_q[0]   <= pend_c_q[1];
			pend_r_q[0]   <= pend_r_q[1];
			pend_ctl_q[0] <= pend_ctl_q[1];
		end
	end

	lwa_stencil #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_stencil (
		.clk                  (clk),
		.arst_n               (arst_n),
		.job_valid            (job_valid),
		.job_ready            (job_ready),
		.job_ctl              (job_ctl),
		.job_l                (job_l),
		.job_c                (job_c),
		.job_r                (job_r),
		.half_courant         (hc_q),
		.half_courant_squared (hcs_q),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.out_ctl              (out_ctl),
		.out_value            (next_sample)
	);

	assign point_index = out_ctl.index;
	assign last_of_run = out_ctl.last;
	assign row_done    = out_ctl.done;

	// end of row always closes the run of results
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_done |-> last_of_run)
		else $error("row end result not marked last of run");

	// a sample that ends the row restarts the counter
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_last |=> sample_count_q == '0)
		else $error("sample counter did not return to zero at row end");

	// at most two jobs ever wait behind the one issued with the sample
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3)
		else $error("pending job count out of range");

	// a three-result sample leaves two jobs waiting, and no sample is taken while they wait
	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && job_n == 2'd3 |=> pend_cnt_q == 2'd2 && !in_ready)
		else $error("three-result sample did not hold the input");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// testbench for the lax-wendroff advection step: predicted stencil results checked per point
`timescale 1ns / 100ps

module tb_top;

	localparam int SW             = lwa_pkg::DEF_SAMPLE_WIDTH;
	localparam int IXW            = lwa_pkg::INDEX_WIDTH;
	localparam int CFW            = lwa_pkg::COEF_WIDTH;
	localparam int CNW            = lwa_pkg::COUNT_WIDTH;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 240;
	localparam int ABOVE_ITEMS    = 8;
	localparam int MAX_PRINTED    = 50;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (SW - 1)) - 128'sd1;
	localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (SW - 1));

	typedef struct {
		logic [IXW-1:0] index;
		logic [SW-1:0]  value;
		logic           last_run;
		logic           row_end;
	} point_t;

	logic                   clk;
	logic                   arst_n      = 1'b0;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index   = '0;
	logic [CFW-1:0]         cfg_data    = '0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic signed [SW-1:0]   prev_sample = '0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic [IXW-1:0]         point_index;
	logic signed [SW-1:0]   next_sample;
	logic                   last_of_run;
	logic                   row_done;

	// shadow copy of the configuration and of the row state
	logic [CNW-1:0]         pc_reg   = CNW'(lwa_pkg::MIN_POINTS);
	logic [1:0]             mode_reg = lwa_pkg::MODE_FIXED;
	logic signed [31:0]     hc_reg   = '0;
	logic signed [31:0]     hcs_reg  = '0;
	logic signed [SW-1:0]   left_s   = '0;
	logic signed [SW-1:0]   center_s = '0;
	logic signed [SW-1:0]   first_s  = '0;
	logic signed [SW-1:0]   second_s = '0;
	int                     row_pos  = 0;

	point_t expected_points[$];

	int items_sent      = 0;
	int results_checked = 0;
	int config_writes   = 0;
	int error_count     = 0;
	bit no_idle         = 1'b0;

	lax_wendroff_advection_step u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.prev_sample (prev_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_index (point_index),
		.next_sample (next_sample),
		.last_of_run (last_of_run),
		.row_done    (row_done)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return '0;
				default: return '1;
			endcase
		end
		if (r < 6)
			return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
		return $urandom;
	endfunction

	// c - hc*(r - l) + hcs*(r + l - 2c), exact, rounded half up, saturated
	function automatic logic [SW-1:0] lw_update(input logic signed [SW-1:0] l,
			input logic signed [SW-1:0] c, input logic signed [SW-1:0] r);
		logic signed [127:0] acc, hc_w, hcs_w;
		hc_w  = hc_reg;
		hcs_w = hcs_reg;
		acc = r * (hcs_w - hc_w) + l * (hcs_w + hc_w)
			+ c * ((128'sd1 <<< lwa_pkg::COEF_FRAC) - 2 * hcs_w)
			+ (128'sd1 <<< (lwa_pkg::COEF_FRAC - 1));
		acc = acc >>> lwa_pkg::COEF_FRAC;
		if (acc > SAT_HI)
			return SAT_HI[SW-1:0];
		if (acc < SAT_LO)
			return SAT_LO[SW-1:0];
		return acc[SW-1:0];
	endfunction

	function automatic point_t mk_point(input int idx, input logic [SW-1:0] v);
		point_t p;
		p.index    = idx[IXW-1:0];
		p.value    = v;
		p.last_run = 1'b0;
		p.row_end  = 1'b0;
		return p;
	endfunction

	// moves the shadow row state by one sample and queues the points it yields
	task automatic advance_row(input logic signed [SW-1:0] x);
		int n, idx;
		logic [1:0] m;
		bit at_end, done;
		logic [SW-1:0] v;
		point_t run_pts[$];
		m    = (mode_reg == MODE_UNUSED) ? lwa_pkg::MODE_FIXED : mode_reg;
		n    = pc_reg;
		if (n < lwa_pkg::MIN_POINTS)
			n = lwa_pkg::MIN_POINTS;
		if (n > lwa_pkg::INDEX_LIMIT)
			n = lwa_pkg::INDEX_LIMIT;
		idx    = row_pos;
		at_end = idx >= 2 && idx >= n - 1;
		done   = 1'b0;
		if (idx == 0) begin
			first_s  = x;
			center_s = x;
			if (m == lwa_pkg::MODE_FIXED)
				run_pts.push_back(mk_point(0, x));
			row_pos = 1;
		end else if (idx == 1) begin
			second_s = x;
			left_s   = center_s;
			center_s = x;
			row_pos  = 2;
		end else begin
			v = lw_update(left_s, center_s, x);
			if (m == lwa_pkg::MODE_FREE && idx == 2)
				run_pts.push_back(mk_point(0, v));
			run_pts.push_back(mk_point(idx - 1, v));
			if (at_end) begin
				if (m == lwa_pkg::MODE_PERIODIC) begin
					run_pts.push_back(mk_point(idx, lw_update(center_s, x, first_s)));
					run_pts.push_back(mk_point(0, lw_update(x, first_s, second_s)));
				end else if (m == lwa_pkg::MODE_FREE) begin
					run_pts.push_back(mk_point(idx, v));
				end else begin
					run_pts.push_back(mk_point(idx, x));
				end
				done    = 1'b1;
				row_pos = 0;
			end else begin
				row_pos = idx + 1;
			end
			left_s   = center_s;
			center_s = x;
		end
		if (run_pts.size() > 0) begin
			run_pts[$].last_run = 1'b1;
			run_pts[$].row_end  = done;
		end
		foreach (run_pts[i])
			expected_points.push_back(run_pts[i]);
	endtask

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic send_sample(input logic [SW-1:0] x);
		int gap;
		prev_sample <= x;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		advance_row(x);
		items_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// all predicted points out, then a settling wait for a sample still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes follow without a gap
	task automatic put_reg(input lwa_pkg::reg_idx_t ri, input logic [CFW-1:0] data);
		cfg_index <= ri;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (ri)
			lwa_pkg::REG_POINT_COUNT:   pc_reg   = data[CNW-1:0];
			lwa_pkg::REG_BOUNDARY_MODE: mode_reg = data[1:0];
			lwa_pkg::REG_HALF_COURANT:  hc_reg   = data;
			lwa_pkg::REG_HALF_COURANT2: hcs_reg  = data;
			default: ;
		endcase
		config_writes++;
	endtask

	task automatic set_config(input logic [CNW-1:0] pc, input logic [1:0] md,
			input logic [31:0] hc, input logic [31:0] hcs);
		wait_idle();
		// unused upper bits carry junk, the block keeps only the register width
		put_reg(lwa_pkg::REG_POINT_COUNT, {(CFW - CNW)'($urandom), pc});
		put_reg(lwa_pkg::REG_BOUNDARY_MODE, {(CFW - 2)'($urandom), md});
		put_reg(lwa_pkg::REG_HALF_COURANT, hc);
		put_reg(lwa_pkg::REG_HALF_COURANT2, hcs);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_fixed_ends();
		set_config(17'd3, lwa_pkg::MODE_FIXED, 32'h1000_0000, 32'h0800_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h0001_0000);
	endtask

	task automatic test_periodic_ends();
		set_config(17'd4, lwa_pkg::MODE_PERIODIC, 32'h1000_0000, 32'h0800_0000);
		send_sample(32'h0002_0000);
		send_sample(32'hFFFF_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
	endtask

	task automatic test_free_ends();
		set_config(17'd4, lwa_pkg::MODE_FREE, 32'hF000_0000, 32'h0800_0000);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0001_8000);
		send_sample(32'h7FFF_0000);
	endtask

	// point counts below three, the unused mode code, coefficients that saturate
	task automatic test_clamped_settings();
		set_config(17'd0, MODE_UNUSED, 32'h1000_0000, 32'h0800_0000);
		send_sample(32'h1234_5678);
		send_sample(32'h0000_0001);
		send_sample(32'h8000_0001);
		set_config(17'd1, lwa_pkg::MODE_PERIODIC, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
	endtask

	task automatic test_mid_row_change();
		set_config(17'h1_0000, lwa_pkg::MODE_FREE, 32'h1000_0000, 32'h0800_0000);
		repeat (3) send_sample(pick_sample());
		// counter already past the new last index: row ends on the next sample
		set_config(17'd3, lwa_pkg::MODE_FIXED, 32'h1000_0000, 32'h0800_0000);
		send_sample(pick_sample());
		set_config(17'd6, lwa_pkg::MODE_PERIODIC, 32'h0400_0000, 32'h0080_0000);
		repeat (2) send_sample(pick_sample());
		set_config(17'd5, lwa_pkg::MODE_FREE, 32'h0400_0000, 32'h0080_0000);
		repeat (3) send_sample(pick_sample());
	endtask

	task automatic test_random_rows();
		int target, n, cnt, eff, r;
		longint rho;
		logic [1:0] md;
		logic [31:0] hc, hcs;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				n = $urandom_range(3, 10);
			else if (r < 9)
				n = $urandom_range(11, 40);
			else
				n = $urandom_range(0, 2);
			md = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0) begin
				// physical courant number in [-1, 1]
				rho = $urandom_range(0, 32'h4000_0000);
				if ($urandom_range(0, 1) != 0)
					rho = -rho;
				hc  = 32'(rho / 2);
				hcs = 32'((rho * rho) >>> 31);
			end else begin
				hc  = $urandom;
				hcs = $urandom;
			end
			set_config(17'(n), md, hc, hcs);
			no_idle = ($urandom_range(0, 3) == 0);
			eff = (n < lwa_pkg::MIN_POINTS) ? lwa_pkg::MIN_POINTS : n;
			// mostly whole rows, sometimes a row cut off by the next setting
			if ($urandom_range(0, 4) == 0)
				cnt = $urandom_range(1, 2 * eff);
			else
				cnt = eff * $urandom_range(1, 3);
			repeat (cnt) send_sample(pick_sample());
		end
		no_idle = 1'b0;
	endtask

	// point count above the index range acts as the limit, so no row end here
	task automatic test_count_above_limit();
		set_config(17'h1_FFFF, lwa_pkg::MODE_PERIODIC, 32'h0C00_0000, 32'h0480_0000);
		no_idle = 1'b1;
		repeat (ABOVE_ITEMS) send_sample(pick_sample());
		no_idle = 1'b0;
	endtask

	// output side pacing
	initial begin : sink_pacing
		int run_len, stall;
		forever begin
			out_ready <= 1'b1;
			run_len = $urandom_range(1, 12);
			repeat (run_len) @(posedge clk);
			stall = no_idle ? 0 : pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		point_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			results_checked++;
			if (expected_points.size() == 0) begin
				report_error($sformatf("result for point %0d with no prediction", point_index));
			end else begin
				want = expected_points.pop_front();
				if (point_index !== want.index)
					report_error($sformatf("point_index %0d, predicted %0d",
						point_index, want.index));
				if (next_sample !== want.value)
					report_error($sformatf("next_sample %h at point %0d, predicted %h",
						next_sample, want.index, want.value));
				if (last_of_run !== want.last_run)
					report_error($sformatf("last_of_run %b at point %0d, predicted %b",
						last_of_run, want.index, want.last_run));
				if (row_done !== want.row_end)
					report_error($sformatf("row_done %b at point %0d, predicted %b",
						row_done, want.index, want.row_end));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1)
					|| (out_valid === 1'b1 && out_ready === 1'b1)
					|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles, %0d points outstanding",
			WATCHDOG_LIMIT, expected_points.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_fixed_ends();
		test_periodic_ends();
		test_free_ends();
		test_clamped_settings();
		test_mid_row_change();
		test_random_rows();
		test_count_above_limit();
		wait_idle();
		$display("run: %0d samples in, %0d points checked, %0d register writes, %0d errors",
			items_sent, results_checked, config_writes, error_count);
		$display("covered fixed, periodic and free ends, the unused mode, clamped counts");
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
